// ===== src/trial_division_factorizer_macros.svh =====
// ----------------------------------------------------------------------------
// Trial division factorizer assertion macros
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define TDF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define TDF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Widths, defaults and the command and status bundles of the block.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int NUM_W             = 27;
   localparam int EXP_W             = 5;
   localparam int DIV_CNT_W         = $clog2(NUM_W + 1);
   localparam int PRIME_BOUND_DEF   = 10240;
   localparam int TABLE_DEPTH_DEF   = 2048;

   typedef struct packed {
      logic clr;
      logic sv_rd;
      logic sv_chk;
      logic sv_next;
      logic mark;
      logic load;
      logic tab_rd;
      logic sq;
      logic div_start;
      logic div_take;
      logic next_p;
      logic emit;
      logic fin_emit;
      logic push_last;
      logic one_out;
   } tdf_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sv_last;
      logic comp_bit;
      logic mark_done;
      logic x_small;
      logic exhausted;
      logic sq_gt;
      logic div_busy;
      logic rem_zero;
      logic e_nz;
      logic pend_valid;
      logic slot_free;
   } tdf_stat_type;

endpackage

// ===== src/tdf_dpath.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer datapath
// Sieve bitmap, prime table, squarer, serial divider and result registers.
// ----------------------------------------------------------------------------
module tdf_dpath
   import tdf_pkg::*;
#(
   parameter int PRIME_BOUND = PRIME_BOUND_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tdf_cmd_type        cmd,
   output tdf_stat_type       stat,
   input  logic [NUM_W-1:0]   req_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NUM_W-1:0]   rsp_prime,
   output logic [EXP_W-1:0]   rsp_exponent,
   output logic               rsp_last
);

   localparam int PW  = $clog2(PRIME_BOUND + 1);
   localparam int IW  = $clog2(PRIME_BOUND + 2);
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int SQW = 2 * PW;
   localparam int MW  = (SQW > NUM_W) ? SQW : NUM_W;

   logic              comp_mem [0:PRIME_BOUND];
   logic [PW-1:0]     tab_mem  [0:TABLE_DEPTH-1];

   logic              comp_rd_ff;
   logic [PW-1:0]     tab_rd_ff;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW:0]       j_ff, j_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [NUM_W-1:0]  x_ff, x_in;
   logic [EXP_W-1:0]  e_ff, e_in;
   logic [PW-1:0]     p_ff;
   logic [SQW-1:0]    sq_ff;
   logic [PW-1:0]     r_ff, r_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [NUM_W-1:0]  pend_p_ff, pend_p_in;
   logic [EXP_W-1:0]  pend_e_ff, pend_e_in;
   logic              pend_v_ff, pend_v_in;
   logic              rsp_v_ff, rsp_v_in;
   logic [NUM_W-1:0]  rsp_p_ff, rsp_p_in;
   logic [EXP_W-1:0]  rsp_e_ff, rsp_e_in;
   logic              rsp_l_ff, rsp_l_in;
   logic [PW:0]       sh;
   logic              ge;
   logic              slot_free;
   logic              comp_we;
   logic              comp_wd;
   logic [PW-1:0]     comp_wa;
   logic              tab_we;

   assign slot_free = !rsp_v_ff || !rsp_stall;
   assign sh        = {r_ff, q_ff[NUM_W-1]};
   assign ge        = sh >= {1'b0, p_ff};

   assign comp_we = cmd.clr || cmd.mark;
   assign comp_wd = cmd.mark;
   assign comp_wa = cmd.mark ? j_ff[PW-1:0] : i_ff[PW-1:0];
   assign tab_we  = cmd.sv_chk && !comp_rd_ff && (count_ff < CW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (comp_we) begin
         comp_mem[comp_wa] <= comp_wd;
      end
      if (cmd.sv_rd) begin
         comp_rd_ff <= comp_mem[i_ff[PW-1:0]];
      end
      if (tab_we) begin
         tab_mem[count_ff[TAW-1:0]] <= i_ff[PW-1:0];
      end
      if (cmd.tab_rd) begin
         tab_rd_ff <= tab_mem[idx_ff[TAW-1:0]];
      end
      if (cmd.sq) begin
         p_ff  <= tab_rd_ff;
         sq_ff <= SQW'(tab_rd_ff) * SQW'(tab_rd_ff);
      end
   end

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      e_in      = e_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      dcnt_in   = dcnt_ff;
      pend_p_in = pend_p_ff;
      pend_e_in = pend_e_ff;
      pend_v_in = pend_v_ff;
      rsp_v_in  = rsp_v_ff && rsp_stall;
      rsp_p_in  = rsp_p_ff;
      rsp_e_in  = rsp_e_ff;
      rsp_l_in  = rsp_l_ff;

      if (cmd.clr) begin
         i_in = (i_ff == IW'(PRIME_BOUND)) ? IW'(2) : i_ff + IW'(1);
      end
      if (cmd.sv_next) begin
         i_in = i_ff + IW'(1);
      end
      if (cmd.sv_chk && !comp_rd_ff) begin
         j_in = (IW+1)'(i_ff) + (IW+1)'(i_ff);
         if (count_ff < CW'(TABLE_DEPTH)) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.mark) begin
         j_in = j_ff + (IW+1)'(i_ff);
      end
      if (cmd.load) begin
         x_in      = req_number;
         idx_in    = '0;
         e_in      = '0;
         pend_v_in = 1'b0;
      end
      if (cmd.div_start) begin
         r_in    = '0;
         q_in    = x_ff;
         dcnt_in = DIV_CNT_W'(NUM_W);
      end else if (dcnt_ff != '0) begin
         r_in    = ge ? PW'(sh - {1'b0, p_ff}) : sh[PW-1:0];
         q_in    = {q_ff[NUM_W-2:0], ge};
         dcnt_in = dcnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.div_take) begin
         x_in = q_ff;
         e_in = e_ff + EXP_W'(1);
      end
      if (cmd.next_p) begin
         idx_in = idx_ff + CW'(1);
         e_in   = '0;
      end
      if (cmd.emit || cmd.fin_emit) begin
         if (pend_v_ff) begin
            rsp_v_in = 1'b1;
            rsp_p_in = pend_p_ff;
            rsp_e_in = pend_e_ff;
            rsp_l_in = 1'b0;
         end
         pend_v_in = 1'b1;
         pend_p_in = cmd.emit ? NUM_W'(p_ff) : x_ff;
         pend_e_in = cmd.emit ? e_ff : EXP_W'(1);
      end
      if (cmd.emit) begin
         idx_in = idx_ff + CW'(1);
         e_in   = '0;
      end
      if (cmd.push_last) begin
         rsp_v_in  = 1'b1;
         rsp_p_in  = pend_p_ff;
         rsp_e_in  = pend_e_ff;
         rsp_l_in  = 1'b1;
         pend_v_in = 1'b0;
      end
      if (cmd.one_out) begin
         rsp_v_in = 1'b1;
         rsp_p_in = x_ff;
         rsp_e_in = '0;
         rsp_l_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         count_ff  <= '0;
         dcnt_ff   <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         i_ff      <= i_in;
         count_ff  <= count_in;
         dcnt_ff   <= dcnt_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
      j_ff      <= j_in;
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      e_ff      <= e_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      pend_p_ff <= pend_p_in;
      pend_e_ff <= pend_e_in;
      rsp_p_ff  <= rsp_p_in;
      rsp_e_ff  <= rsp_e_in;
      rsp_l_ff  <= rsp_l_in;
   end

   always_comb begin
      stat.clr_last   = i_ff == IW'(PRIME_BOUND);
      stat.sv_last    = i_ff == IW'(PRIME_BOUND);
      stat.comp_bit   = comp_rd_ff;
      stat.mark_done  = j_ff > (IW+1)'(PRIME_BOUND);
      stat.x_small    = x_ff <= NUM_W'(1);
      stat.exhausted  = idx_ff == count_ff;
      stat.sq_gt      = MW'(sq_ff) > MW'(x_ff);
      stat.div_busy   = dcnt_ff != '0;
      stat.rem_zero   = r_ff == '0;
      stat.e_nz       = e_ff != '0;
      stat.pend_valid = pend_v_ff;
      stat.slot_free  = slot_free;
   end

   assign rsp_valid    = rsp_v_ff;
   assign rsp_prime    = rsp_p_ff;
   assign rsp_exponent = rsp_e_ff;
   assign rsp_last     = rsp_l_ff;

endmodule

// ===== src/tdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer controller
// Sequences the table sieve after reset and the per-item factoring loop.
// ----------------------------------------------------------------------------
module tdf_ctrl
   import tdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tdf_stat_type stat,
   output tdf_cmd_type  cmd
);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_SVRD   = 4'd1;
   localparam logic [3:0] S_SVCHK  = 4'd2;
   localparam logic [3:0] S_MARK   = 4'd3;
   localparam logic [3:0] S_IDLE   = 4'd4;
   localparam logic [3:0] S_CHK0   = 4'd5;
   localparam logic [3:0] S_RD     = 4'd6;
   localparam logic [3:0] S_SQ     = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_DSTART = 4'd9;
   localparam logic [3:0] S_DWAIT  = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;
   localparam logic [3:0] S_LAST   = 4'd13;

   logic [3:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_SVRD;
            end
         end
         S_SVRD: begin
            cmd.sv_rd = 1'b1;
            state_in  = S_SVCHK;
         end
         S_SVCHK: begin
            if (!stat.comp_bit) begin
               cmd.sv_chk = 1'b1;
               state_in   = S_MARK;
            end else if (stat.sv_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.sv_next = 1'b1;
               state_in    = S_SVRD;
            end
         end
         S_MARK: begin
            if (!stat.mark_done) begin
               cmd.mark = 1'b1;
            end else if (stat.sv_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.sv_next = 1'b1;
               state_in    = S_SVRD;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            if (!stat.x_small) begin
               state_in = S_RD;
            end else if (stat.slot_free) begin
               cmd.one_out = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_RD: begin
            if (stat.exhausted) begin
               state_in = S_FIN;
            end else begin
               cmd.tab_rd = 1'b1;
               state_in   = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = stat.sq_gt ? S_FIN : S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  cmd.div_take = 1'b1;
                  state_in     = S_DSTART;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (!stat.e_nz) begin
               cmd.next_p = 1'b1;
               state_in   = S_RD;
            end else if (!stat.pend_valid || stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (stat.x_small) begin
               state_in = S_LAST;
            end else if (!stat.pend_valid || stat.slot_free) begin
               cmd.fin_emit = 1'b1;
               state_in     = S_LAST;
            end
         end
         S_LAST: begin
            if (stat.slot_free) begin
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/trial_division_factorizer.sv =====
// Each trial division by a table prime runs through the bit-serial divider.
// One item is factored at a time; results leave through a single output register.
// Reset (synchronous) clears the sieve bitmap, entries 0 to PRIME_BOUND, then sieves the
// prime table, marking every multiple of each prime that it finds up to PRIME_BOUND;
// no item is accepted until that finishes.
// ----------------------------------------------------------------------------
// Trial division factorizer
// Factors a number into ascending prime and exponent pairs by trial division.
// ----------------------------------------------------------------------------
`include "trial_division_factorizer_macros.svh"

module trial_division_factorizer
   import tdf_pkg::*;
#(
   parameter int PRIME_BOUND = PRIME_BOUND_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [NUM_W-1:0]   req_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NUM_W-1:0]   rsp_prime,
   output logic [EXP_W-1:0]   rsp_exponent,
   output logic               rsp_last
);

   tdf_cmd_type  cmd;
   tdf_stat_type stat;

   tdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tdf_dpath #(
      .PRIME_BOUND (PRIME_BOUND),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prime    (rsp_prime),
      .rsp_exponent (rsp_exponent),
      .rsp_last     (rsp_last)
   );

   `TDF_ASSERT_IMP(a_one_writer, 1'b1, $onehot0({cmd.emit, cmd.fin_emit, cmd.push_last, cmd.one_out}), "two result writes in one cycle")
   `TDF_ASSERT_IMP(a_final_slot, cmd.push_last || cmd.one_out, stat.slot_free, "final result overwrites a waiting one")
   `TDF_ASSERT_IMP(a_push_slot, (cmd.emit || cmd.fin_emit) && stat.pend_valid, stat.slot_free, "result overwrites a waiting one")
   `TDF_ASSERT_NXT(a_one_item, req_valid && !req_stall, req_stall, "second item taken while one is in work")

endmodule
